// ----- src/hta_pkg.sv -----
// Shared types and constants for the handle table allocator.
package hta_pkg;

  // Field widths of the item streams.
  localparam int ID_W    = 32;
  localparam int SLOT_W  = 6;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int TDATA_W = 40;

  // Configuration port geometry.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Command codes carried in the input tuser.
  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;

  // Status codes carried in the output tuser.
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Register indexes, taken from paddr bit 2.
  localparam logic CFG_IDX_MARKER = 1'b0;
  localparam logic CFG_IDX_START  = 1'b1;

  // Write events from the register block to the sequencer.
  typedef struct packed {
    logic            marker_wr;
    logic            start_wr;
    logic [ID_W-1:0] wdata;
  } cfg_evt_t;

endpackage

// ----- src/hta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hta_cfg.sv -----
// Configuration register block behind the APB-style port.
module hta_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [hta_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [hta_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [hta_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output logic [hta_pkg::ID_W-1:0]     empty_marker,
  output hta_pkg::cfg_evt_t            evt
);

  import hta_pkg::*;

  logic [ID_W-1:0] empty_marker_r;
  logic [ID_W-1:0] start_id_r;
  logic            wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Decode write strobes; the sequencer reacts in the same cycle.
  always_comb begin
    evt.marker_wr = wr_en && (cfg_paddr[2] == CFG_IDX_MARKER);
    evt.start_wr  = wr_en && (cfg_paddr[2] == CFG_IDX_START);
    evt.wdata     = cfg_pwdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_marker_r <= '0;
      start_id_r     <= '0;
    end else begin
      if (evt.marker_wr) begin
        empty_marker_r <= cfg_pwdata;
      end
      if (evt.start_wr) begin
        start_id_r <= cfg_pwdata;
      end
    end
  end

  // Read back.
  assign cfg_prdata   = (cfg_paddr[2] == CFG_IDX_START) ? start_id_r : empty_marker_r;
  assign empty_marker = empty_marker_r;

endmodule

// ----- src/handle_table_allocator.sv -----
// Handle table allocator: one command item in, one result item out, scanning a slot RAM.
// A check reads the slot (S_LOOK) and compares it (S_CMP), a release writes the marker into
// the slot (S_REL), undefined commands go straight to S_DONE, and a register scans the table;
// one slot is read per cycle through one shared compare. An item holds the block until its
// result moves to the output register; a new item is taken while the previous result waits.
// Reset (synchronous, rst_n low) and every empty_marker write start a clearing pass that
// writes the marker into every slot; no item is accepted meanwhile.
module handle_table_allocator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // APB-style configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [hta_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [hta_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [hta_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  // Command items
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [hta_pkg::TDATA_W-1:0]  in_tdata,  // handle_id[31:0], slot_index[37:32]
  input  logic [hta_pkg::CMD_W-1:0]    in_tuser,  // command[1:0]
  // Result items
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [hta_pkg::TDATA_W-1:0]  out_tdata, // issued_id[31:0], issued_slot[37:32]
  output logic [hta_pkg::ST_W-1:0]     out_tuser  // status[1:0]
);

  import hta_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WIDE_W = ((ADDR_W > SLOT_W) ? ADDR_W : SLOT_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_LOOK  = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_REL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_pos_r, clr_pos_nxt;
  logic [ADDR_W-1:0] scan_pos_r, scan_pos_nxt;
  logic [CNT_W-1:0]  issued_cnt_r, issued_cnt_nxt;
  logic [ADDR_W-1:0] cmp_pos_r, cmp_pos_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [ADDR_W-1:0] search_start_r, search_start_nxt;
  logic [ID_W-1:0]   id_counter_r, id_counter_nxt;
  logic [ID_W-1:0]   hid_r, hid_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;

  logic [ID_W-1:0]   empty_marker;
  cfg_evt_t          cfg_evt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ID_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ID_W-1:0]   ram_rdata;

  logic [WIDE_W-1:0] slot_wide;
  logic [WIDE_W-1:0] cmp_pos_wide;
  logic              slot_in_range;
  logic [ADDR_W-1:0] slot_addr;
  logic [ID_W-1:0]   cmp_ref;
  logic              cmp_eq;
  logic [ID_W-1:0]   id_inc;
  logic              in_fire;

  // Configuration registers.
  hta_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .empty_marker (empty_marker),
    .evt          (cfg_evt)
  );

  // Slot ID table.
  hta_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Slot range check and address forms.
  assign slot_wide     = WIDE_W'(slot_r);
  assign slot_in_range = slot_wide < WIDE_W'(TABLE_DEPTH);
  assign slot_addr     = slot_wide[ADDR_W-1:0];
  assign cmp_pos_wide  = WIDE_W'(cmp_pos_r);

  // Shared compare unit: empty marker while scanning, given ID while checking.
  assign cmp_ref = (state_r == S_SCAN) ? empty_marker : hid_r;
  assign cmp_eq  = (ram_rdata == cmp_ref);
  assign id_inc  = id_counter_r + ID_W'(1);

  assign ram_raddr = (state_r == S_SCAN) ? scan_pos_r : slot_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    clr_pos_nxt      = clr_pos_r;
    scan_pos_nxt     = scan_pos_r;
    issued_cnt_nxt   = issued_cnt_r;
    cmp_pos_nxt      = cmp_pos_r;
    cmp_vld_nxt      = cmp_vld_r;
    search_start_nxt = search_start_r;
    id_counter_nxt   = id_counter_r;
    hid_nxt          = hid_r;
    slot_nxt         = slot_r;
    res_status_nxt   = res_status_r;
    res_id_nxt       = res_id_r;
    res_slot_nxt     = res_slot_r;
    out_vld_nxt      = out_vld_r & ~out_tready;
    out_status_nxt   = out_status_r;
    out_id_nxt       = out_id_r;
    out_slot_nxt     = out_slot_r;
    ram_we           = 1'b0;
    ram_waddr        = slot_addr;
    ram_wdata        = empty_marker;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_pos_r;
        if (clr_pos_r == LAST_POS) begin
          state_nxt = S_IDLE;
        end else begin
          clr_pos_nxt = clr_pos_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          hid_nxt        = in_tdata[ID_W-1:0];
          slot_nxt       = in_tdata[ID_W+SLOT_W-1:ID_W];
          res_status_nxt = ST_BAD;
          res_id_nxt     = '0;
          res_slot_nxt   = '0;
          case (in_tuser)
            CMD_REGISTER: begin
              state_nxt      = S_SCAN;
              scan_pos_nxt   = search_start_r;
              issued_cnt_nxt = '0;
              cmp_vld_nxt    = 1'b0;
            end
            CMD_CHECK:   state_nxt = S_LOOK;
            CMD_RELEASE: state_nxt = S_REL;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && cmp_eq) begin
          // Empty slot found: claim it with the next ID.
          ram_we           = 1'b1;
          ram_waddr        = cmp_pos_r;
          ram_wdata        = id_inc;
          id_counter_nxt   = id_inc;
          search_start_nxt = cmp_pos_r;
          res_status_nxt   = ST_OK;
          res_id_nxt       = id_inc;
          res_slot_nxt     = cmp_pos_wide[SLOT_W-1:0];
          state_nxt        = S_DONE;
        end else if (!cmp_vld_r && (issued_cnt_r == FULL_CNT)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else if (issued_cnt_r != FULL_CNT) begin
          // Read one more slot; its data is compared next cycle.
          cmp_pos_nxt    = scan_pos_r;
          cmp_vld_nxt    = 1'b1;
          issued_cnt_nxt = issued_cnt_r + CNT_W'(1);
          scan_pos_nxt   = (scan_pos_r == LAST_POS) ? '0 : scan_pos_r + ADDR_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end
      S_LOOK: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        res_status_nxt = (slot_in_range && cmp_eq) ? ST_OK : ST_BAD;
        state_nxt      = S_DONE;
      end
      S_REL: begin
        ram_we         = slot_in_range;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new empty marker empties the whole table again.
    if (cfg_evt.marker_wr) begin
      state_nxt        = S_CLEAR;
      clr_pos_nxt      = '0;
      search_start_nxt = '0;
    end
    if (cfg_evt.start_wr) begin
      id_counter_nxt = cfg_evt.wdata;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_pos_r      <= '0;
      scan_pos_r     <= '0;
      issued_cnt_r   <= '0;
      cmp_vld_r      <= 1'b0;
      search_start_r <= '0;
      id_counter_r   <= '0;
      out_vld_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_pos_r      <= clr_pos_nxt;
      scan_pos_r     <= scan_pos_nxt;
      issued_cnt_r   <= issued_cnt_nxt;
      cmp_vld_r      <= cmp_vld_nxt;
      search_start_r <= search_start_nxt;
      id_counter_r   <= id_counter_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_pos_r    <= cmp_pos_nxt;
    hid_r        <= hid_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(TDATA_W - ID_W - SLOT_W){1'b0}}, out_slot_r, out_id_r};

endmodule

// ----- src/hta_checker.sv -----
// Port-level checker for the handle table allocator, bound to the top level.
module hta_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [hta_pkg::TDATA_W-1:0]  out_tdata,
  input logic [hta_pkg::ST_W-1:0]     out_tuser
);

  import hta_pkg::*;

  // The table is cleared after reset, so no item is taken right away.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item accepted during clearing pass");

  // One item in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in work");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

  // Only a successful register carries an ID and slot.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_BAD)) |-> (out_tdata == '0))
    else $error("nonzero payload on failed item");

  // Status is never the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_BAD || out_tuser == ST_FULL))
    else $error("undefined status code");

endmodule

bind handle_table_allocator hta_checker u_hta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
